### sv/srs_pkg.sv
// Shared types and constants for the stick radial shaper.
// No dependencies; imported by every module of the block.
package srs_pkg;

    localparam int CURVE_ENTRIES = 131;
    localparam int CURVE_IDX_W   = (CURVE_ENTRIES > 1) ? $clog2(CURVE_ENTRIES) : 1;
    localparam int CURVE_MAX     = CURVE_ENTRIES - 1;

    localparam logic [1:0] CFG_GAIN      = 2'd0;
    localparam logic [1:0] CFG_DEAD_ZONE = 2'd1;
    localparam logic [1:0] CFG_LIMIT     = 2'd2;
    localparam logic [1:0] CFG_CURVE_EN  = 2'd3;

    localparam logic [15:0] GAIN_RST  = 16'd256;
    localparam logic [7:0]  DZ_RST    = 8'd0;
    localparam logic [7:0]  LIMIT_RST = 8'd255;

    // magnitude stage -> scale stage
    typedef struct packed {
        logic        valid;
        logic        x_nz;
        logic        x_neg;
        logic        y_neg;
        logic        y_pos;
        logic [30:0] ax2;
        logic [30:0] ay2;
        logic [31:0] s;
        logic [15:0] m;
    } mag_t;

    // scale stage -> output buffer
    typedef struct packed {
        logic        valid;
        logic [16:0] x_out;
        logic [16:0] y_out;
    } res_t;

endpackage

### sv/srs_mag.sv
// Magnitude path: squares, gain, pipelined 64-bit square root, curve table,
// dead zone and limit. Depends on srs_pkg.
module srs_mag (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  logic               func,
    input  logic signed [15:0] x_in,
    input  logic signed [15:0] y_in,
    input  logic [7:0]         entry_index,
    input  logic [7:0]         entry_value,
    input  logic [15:0]        gain,
    input  logic [7:0]         dead_zone,
    input  logic [7:0]         limit,
    input  logic               curve_enable,
    output srs_pkg::mag_t      mag
);
    import srs_pkg::*;

    localparam int SQ = 32;

    typedef struct packed {
        logic       func;
        logic       x_nz;
        logic       x_neg;
        logic       y_neg;
        logic       y_pos;
        logic [7:0] eidx;
        logic [7:0] eval;
    } side_t;

    typedef struct packed {
        side_t       side;
        logic [30:0] ax2;
        logic [30:0] ay2;
        logic [31:0] s;
    } carry_t;

    // input conditioning
    logic [15:0] x_u, y_u, ax, ay;
    logic [31:0] ax_sq, ay_sq, g_sq;
    side_t       side_in;

    assign x_u   = x_in;
    assign y_u   = y_in;
    assign ax    = x_in[15] ? 16'(~x_u + 16'd1) : x_u;
    assign ay    = y_in[15] ? 16'(~y_u + 16'd1) : y_u;
    assign ax_sq = ax * ax;
    assign ay_sq = ay * ay;
    assign g_sq  = gain * gain;

    always_comb
    begin
        side_in.func  = func;
        side_in.x_nz  = (x_in != 16'sd0);
        side_in.x_neg = x_in[15];
        side_in.y_neg = y_in[15];
        side_in.y_pos = !y_in[15] && (y_in != 16'sd0);
        side_in.eidx  = entry_index;
        side_in.eval  = entry_value;
    end

    // stage 1 / 2
    logic        v1_reg, v2_reg;
    side_t       side1_reg, side2_reg;
    logic [30:0] ax2_1_reg, ay2_1_reg, ax2_2_reg, ay2_2_reg;
    logic [31:0] g2_1_reg, g2_2_reg, s2_reg;
    logic [31:0] s2_next;
    logic [63:0] p3_next;

    assign s2_next = 32'(ax2_1_reg) + 32'(ay2_1_reg);
    assign p3_next = s2_reg * g2_2_reg;

    // square root stages
    logic        sq_v_reg [0:SQ];
    carry_t      sq_c_reg [0:SQ];
    logic [63:0] sq_n_reg [0:SQ];
    logic [34:0] sq_r_reg [0:SQ];
    logic [31:0] sq_q_reg [0:SQ];
    logic [63:0] sq_n_next [0:SQ-1];
    logic [34:0] sq_r_next [0:SQ-1];
    logic [31:0] sq_q_next [0:SQ-1];

    always_comb
    begin
        logic [34:0] rt;
        logic [34:0] tt;
        rt = '0;
        tt = '0;
        for (int i = 0; i < SQ; i++)
        begin
            rt = {sq_r_reg[i][32:0], sq_n_reg[i][63:62]};
            tt = 35'({sq_q_reg[i], 2'b01});
            sq_n_next[i] = {sq_n_reg[i][61:0], 2'b00};
            if (rt >= tt)
            begin
                sq_r_next[i] = rt - tt;
                sq_q_next[i] = {sq_q_reg[i][30:0], 1'b1};
            end
            else
            begin
                sq_r_next[i] = rt;
                sq_q_next[i] = {sq_q_reg[i][30:0], 1'b0};
            end
        end
    end

    // curve index
    logic [15:0]            lim8;
    logic [15:0]            ml, rsum;
    logic [7:0]             idx8, idxc;
    logic                   c0_v_reg, c1_v_reg;
    carry_t                 c0_c_reg, c1_c_reg;
    logic [31:0]            c0_m_reg, c1_m_reg;
    logic [CURVE_IDX_W-1:0] c0_idx_reg;
    logic [7:0]             rd_reg;
    logic [7:0]             curve_mem [0:CURVE_ENTRIES-1];
    logic                   wr_ok;

    assign lim8 = {limit, 8'd0};
    assign ml   = (sq_q_reg[SQ] > 32'(lim8)) ? lim8 : sq_q_reg[SQ][15:0];
    assign rsum = ml + 16'd128;
    assign idx8 = rsum[15:8];
    assign idxc = (idx8 > 8'(CURVE_MAX)) ? 8'(CURVE_MAX) : idx8;
    assign wr_ok = ({1'b0, c0_c_reg.side.eidx} < 9'(CURVE_ENTRIES));

    // dead zone and limit
    logic [31:0] mm;
    logic [32:0] madd;
    logic [15:0] mf;
    mag_t        mag_reg, mag_next;

    always_comb
    begin
        mm   = curve_enable ? {16'd0, rd_reg, 8'd0} : c1_m_reg;
        madd = (mm != 32'd0) ? ({1'b0, mm} + {17'd0, dead_zone, 8'd0}) : {1'b0, mm};
        mf   = (madd > 33'(lim8)) ? lim8 : madd[15:0];
        mag_next.valid = c1_v_reg;
        mag_next.x_nz  = c1_c_reg.side.x_nz;
        mag_next.x_neg = c1_c_reg.side.x_neg;
        mag_next.y_neg = c1_c_reg.side.y_neg;
        mag_next.y_pos = c1_c_reg.side.y_pos;
        mag_next.ax2   = c1_c_reg.ax2;
        mag_next.ay2   = c1_c_reg.ay2;
        mag_next.s     = c1_c_reg.s;
        mag_next.m     = mf;
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            c0_v_reg <= 1'b0;
            c1_v_reg <= 1'b0;
            mag_reg  <= '0;
            for (int i = 0; i <= SQ; i++)
                sq_v_reg[i] <= 1'b0;
        end
        else if (en)
        begin
            v1_reg      <= in_valid;
            v2_reg      <= v1_reg;
            sq_v_reg[0] <= v2_reg;
            for (int i = 0; i < SQ; i++)
                sq_v_reg[i+1] <= sq_v_reg[i];
            c0_v_reg <= sq_v_reg[SQ];
            // curve writes end here
            c1_v_reg <= c0_v_reg && !c0_c_reg.side.func;
            mag_reg  <= mag_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side1_reg <= side_in;
            ax2_1_reg <= ax_sq[30:0];
            ay2_1_reg <= ay_sq[30:0];
            g2_1_reg  <= g_sq;
            side2_reg <= side1_reg;
            ax2_2_reg <= ax2_1_reg;
            ay2_2_reg <= ay2_1_reg;
            g2_2_reg  <= g2_1_reg;
            s2_reg    <= s2_next;

            sq_c_reg[0].side <= side2_reg;
            sq_c_reg[0].ax2  <= ax2_2_reg;
            sq_c_reg[0].ay2  <= ay2_2_reg;
            sq_c_reg[0].s    <= s2_reg;
            sq_n_reg[0]      <= p3_next;
            sq_r_reg[0]      <= '0;
            sq_q_reg[0]      <= '0;
            for (int i = 0; i < SQ; i++)
            begin
                sq_c_reg[i+1] <= sq_c_reg[i];
                sq_n_reg[i+1] <= sq_n_next[i];
                sq_r_reg[i+1] <= sq_r_next[i];
                sq_q_reg[i+1] <= sq_q_next[i];
            end

            c0_c_reg   <= sq_c_reg[SQ];
            c0_m_reg   <= sq_q_reg[SQ];
            c0_idx_reg <= idxc[CURVE_IDX_W-1:0];
            c1_c_reg   <= c0_c_reg;
            c1_m_reg   <= c0_m_reg;
        end
    end

    // curve table: written and read in the same stage, so order is kept
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (c0_v_reg && c0_c_reg.side.func && wr_ok)
                curve_mem[c0_c_reg.side.eidx[CURVE_IDX_W-1:0]] <= c0_c_reg.side.eval;
            rd_reg <= curve_mem[c0_idx_reg];
        end
    end

    assign mag = mag_reg;

endmodule

### sv/srs_scale.sv
// Direction rebuild: m^2 * v^2 / r^2 through pipelined dividers and
// 32-bit square roots, one lane per axis. Depends on srs_pkg.
module srs_scale (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  srs_pkg::mag_t mag,
    output srs_pkg::res_t res
);
    import srs_pkg::*;

    localparam int DV = 32;
    localparam int SQ = 16;

    typedef struct packed {
        logic        x_nz;
        logic        x_neg;
        logic        y_neg;
        logic        y_pos;
        logic [15:0] m;
    } flag_t;

    // stage D1: m squared
    logic        d1_v_reg;
    flag_t       d1_f_reg;
    logic [31:0] d1_m2_reg, d1_s_reg;
    logic [30:0] d1_ax2_reg, d1_ay2_reg;
    logic [31:0] m2_next;
    logic [62:0] nx_p, ny_p;

    assign m2_next = mag.m * mag.m;
    assign nx_p    = d1_m2_reg * d1_ax2_reg;
    assign ny_p    = d1_m2_reg * d1_ay2_reg;

    // restoring divider stages, lane 0 = x, lane 1 = y
    logic        dv_v_reg [0:DV];
    flag_t       dv_f_reg [0:DV];
    logic [31:0] dv_s_reg [0:DV];
    logic [32:0] dv_r_reg [0:DV][0:1];
    logic [31:0] dv_n_reg [0:DV][0:1];
    logic [31:0] dv_q_reg [0:DV][0:1];
    logic [32:0] dv_r_next [0:DV-1][0:1];
    logic [31:0] dv_q_next [0:DV-1][0:1];

    always_comb
    begin
        logic [32:0] rt;
        logic [32:0] dd;
        rt = '0;
        dd = '0;
        for (int i = 0; i < DV; i++)
        begin
            for (int l = 0; l < 2; l++)
            begin
                rt = {dv_r_reg[i][l][31:0], dv_n_reg[i][l][31]};
                dd = {1'b0, dv_s_reg[i]};
                if (rt >= dd)
                begin
                    dv_r_next[i][l] = rt - dd;
                    dv_q_next[i][l] = {dv_q_reg[i][l][30:0], 1'b1};
                end
                else
                begin
                    dv_r_next[i][l] = rt;
                    dv_q_next[i][l] = {dv_q_reg[i][l][30:0], 1'b0};
                end
            end
        end
    end

    // square root stages
    logic        sq_v_reg [0:SQ];
    flag_t       sq_f_reg [0:SQ];
    logic [31:0] sq_n_reg [0:SQ][0:1];
    logic [18:0] sq_r_reg [0:SQ][0:1];
    logic [15:0] sq_q_reg [0:SQ][0:1];
    logic [18:0] sq_r_next [0:SQ-1][0:1];
    logic [15:0] sq_q_next [0:SQ-1][0:1];

    always_comb
    begin
        logic [18:0] rt;
        logic [18:0] tt;
        rt = '0;
        tt = '0;
        for (int i = 0; i < SQ; i++)
        begin
            for (int l = 0; l < 2; l++)
            begin
                rt = {sq_r_reg[i][l][16:0], sq_n_reg[i][l][31:30]};
                tt = 19'({sq_q_reg[i][l], 2'b01});
                if (rt >= tt)
                begin
                    sq_r_next[i][l] = rt - tt;
                    sq_q_next[i][l] = {sq_q_reg[i][l][14:0], 1'b1};
                end
                else
                begin
                    sq_r_next[i][l] = rt;
                    sq_q_next[i][l] = {sq_q_reg[i][l][14:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d1_v_reg <= 1'b0;
            for (int i = 0; i <= DV; i++)
                dv_v_reg[i] <= 1'b0;
            for (int i = 0; i <= SQ; i++)
                sq_v_reg[i] <= 1'b0;
        end
        else if (en)
        begin
            d1_v_reg    <= mag.valid;
            dv_v_reg[0] <= d1_v_reg;
            for (int i = 0; i < DV; i++)
                dv_v_reg[i+1] <= dv_v_reg[i];
            sq_v_reg[0] <= dv_v_reg[DV];
            for (int i = 0; i < SQ; i++)
                sq_v_reg[i+1] <= sq_v_reg[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d1_f_reg.x_nz  <= mag.x_nz;
            d1_f_reg.x_neg <= mag.x_neg;
            d1_f_reg.y_neg <= mag.y_neg;
            d1_f_reg.y_pos <= mag.y_pos;
            d1_f_reg.m     <= mag.m;
            d1_m2_reg      <= m2_next;
            d1_s_reg       <= mag.s;
            d1_ax2_reg     <= mag.ax2;
            d1_ay2_reg     <= mag.ay2;

            // quotient fits 32 bits since v^2 <= s
            dv_f_reg[0]    <= d1_f_reg;
            dv_s_reg[0]    <= d1_s_reg;
            dv_r_reg[0][0] <= {2'b00, nx_p[62:32]};
            dv_r_reg[0][1] <= {2'b00, ny_p[62:32]};
            dv_n_reg[0][0] <= nx_p[31:0];
            dv_n_reg[0][1] <= ny_p[31:0];
            dv_q_reg[0][0] <= '0;
            dv_q_reg[0][1] <= '0;
            for (int i = 0; i < DV; i++)
            begin
                dv_f_reg[i+1] <= dv_f_reg[i];
                dv_s_reg[i+1] <= dv_s_reg[i];
                for (int l = 0; l < 2; l++)
                begin
                    dv_r_reg[i+1][l] <= dv_r_next[i][l];
                    dv_n_reg[i+1][l] <= {dv_n_reg[i][l][30:0], 1'b0};
                    dv_q_reg[i+1][l] <= dv_q_next[i][l];
                end
            end

            sq_f_reg[0] <= dv_f_reg[DV];
            for (int l = 0; l < 2; l++)
            begin
                sq_n_reg[0][l] <= dv_q_reg[DV][l];
                sq_r_reg[0][l] <= '0;
                sq_q_reg[0][l] <= '0;
            end
            for (int i = 0; i < SQ; i++)
            begin
                sq_f_reg[i+1] <= sq_f_reg[i];
                for (int l = 0; l < 2; l++)
                begin
                    sq_n_reg[i+1][l] <= {sq_n_reg[i][l][29:0], 2'b00};
                    sq_r_reg[i+1][l] <= sq_r_next[i][l];
                    sq_q_reg[i+1][l] <= sq_q_next[i][l];
                end
            end
        end
    end

    // sign and the zero-x special case
    logic [16:0] nx, ny, mz;

    always_comb
    begin
        nx = {1'b0, sq_q_reg[SQ][0]};
        ny = {1'b0, sq_q_reg[SQ][1]};
        mz = {1'b0, sq_f_reg[SQ].m};
        res.valid = sq_v_reg[SQ];
        if (sq_f_reg[SQ].x_nz)
        begin
            res.x_out = sq_f_reg[SQ].x_neg ? 17'(~nx + 17'd1) : nx;
            res.y_out = sq_f_reg[SQ].y_neg ? 17'(~ny + 17'd1) : ny;
        end
        else
        begin
            res.x_out = '0;
            res.y_out = sq_f_reg[SQ].y_pos ? mz : 17'(~mz + 17'd1);
        end
    end

endmodule

### sv/srs_skid.sv
// Two-entry output buffer; its fill level gates the whole pipeline.
// Depends on srs_pkg.
module srs_skid (
    input  logic          clk,
    input  logic          rst_n,
    input  srs_pkg::res_t res,
    output logic          en,
    output logic          out_valid,
    input  logic          out_stall,
    output logic [16:0]   x_out,
    output logic [16:0]   y_out
);
    import srs_pkg::*;

    res_t       buf_reg [0:1];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg, cnt_next;
    logic       push, pop;

    assign en        = (cnt_reg != 2'd2);
    assign push      = en && res.valid;
    assign out_valid = (cnt_reg != 2'd0);
    assign pop       = out_valid && !out_stall;
    assign x_out     = buf_reg[rd_ptr_reg].x_out;
    assign y_out     = buf_reg[rd_ptr_reg].y_out;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + 2'd1;
        else if (pop && !push)
            cnt_next = cnt_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            buf_reg[wr_ptr_reg] <= res;
    end

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3)
        else $error("output buffer overfilled");

    a_cnt_up: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (cnt_reg == $past(cnt_reg) + 2'd1))
        else $error("fill count missed a push");

    a_cnt_down: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !push) |=> (cnt_reg == $past(cnt_reg) - 2'd1))
        else $error("fill count missed a pop");

endmodule

### sv/stick_radial_shaper_top.sv
// Top level of the stick radial shaper: configuration registers, magnitude
// path, direction rebuild and output buffer. Depends on srs_pkg and submodules.
//
// Radial dead zone and response curve for a signed stick vector. One
// transaction can be accepted every clock cycle while in_stall is low; each
// shape transaction (func 0) yields exactly one result after passing the
// 32-step square root of the gained radius, the 32-step dividers and the
// 16-step square roots of the direction rebuild, each one register stage
// per step. Curve write transactions (func 1) travel the same pipeline, store
// their entry in order with the shape transactions around them, and produce
// no result; an entry_index at or beyond the table size is ignored. Curve
// entries are undefined until written and must be written before a shape
// transaction with curve_enable set indexes them. The pipeline feeds a
// two-entry output buffer: in_stall rises only when that buffer is full, so
// input keeps flowing while one result waits. Configuration registers may
// be written only while no transaction is in flight.
module stick_radial_shaper_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               func,
    input  logic signed [15:0] x_in,
    input  logic signed [15:0] y_in,
    input  logic [7:0]         entry_index,
    input  logic [7:0]         entry_value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [16:0] x_out,
    output logic signed [16:0] y_out,
    input  logic               cfg_wr,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data
);
    import srs_pkg::*;

    logic [15:0] gain_reg;
    logic [7:0]  dead_zone_reg;
    logic [7:0]  limit_reg;
    logic        curve_en_reg;

    // configuration register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg      <= GAIN_RST;
            dead_zone_reg <= DZ_RST;
            limit_reg     <= LIMIT_RST;
            curve_en_reg  <= 1'b0;
        end
        else if (cfg_wr)
        begin
            case (cfg_index)
                CFG_GAIN:      gain_reg      <= cfg_data;
                CFG_DEAD_ZONE: dead_zone_reg <= cfg_data[7:0];
                CFG_LIMIT:     limit_reg     <= cfg_data[7:0];
                CFG_CURVE_EN:  curve_en_reg  <= cfg_data[0];
                default:       ;
            endcase
        end
    end

    // global advance: the whole pipeline moves while the buffer has room
    logic        en;
    mag_t        mag;
    res_t        res;
    logic [16:0] x_buf, y_buf;

    assign in_stall = !en;

    srs_mag u_mag (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (en),
        .in_valid     (in_valid),
        .func         (func),
        .x_in         (x_in),
        .y_in         (y_in),
        .entry_index  (entry_index),
        .entry_value  (entry_value),
        .gain         (gain_reg),
        .dead_zone    (dead_zone_reg),
        .limit        (limit_reg),
        .curve_enable (curve_en_reg),
        .mag          (mag)
    );

    srs_scale u_scale (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .mag   (mag),
        .res   (res)
    );

    srs_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .res       (res),
        .en        (en),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .x_out     (x_buf),
        .y_out     (y_buf)
    );

    assign x_out = x_buf;
    assign y_out = y_buf;

endmodule
